>>> design/csvt_pkg.sv
package csvt_pkg;

  // field parser modes
  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_PLAIN  = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_QSEEN  = 3'd3,
    MODE_AFTER  = 3'd4
  } field_mode_e;

  // line break bytes
  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_LF = 8'd10;

  // register reset values
  localparam logic [7:0] SEP_RESET   = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  // register indexes
  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_QUOTE     = 1'b1;

  // result fifo geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // one result transaction
  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       field_end;
    logic       row_end;
    logic       last;
  } result_t;

  // all results caused by one byte, plus the following state
  typedef struct packed {
    logic [1:0]  num;
    result_t     res0;
    result_t     res1;
    field_mode_e mode;
    logic        pending_cr;
  } step_t;

endpackage

>>> design/csvt_step.sv
module csvt_step import csvt_pkg::*; (
  input  logic [7:0]  in_byte_i,
  input  field_mode_e mode_i,
  input  logic        pending_cr_i,
  input  logic [7:0]  sep_i,
  input  logic [7:0]  quote_i,
  output step_t       step_o
);

  typedef struct packed {
    logic        valid;
    result_t     res;
    field_mode_e mode;
  } proc_t;

  // one byte through the field machine, no line break detection
  function automatic proc_t proc_byte(input logic [7:0] b, input field_mode_e m,
                                      input logic [7:0] sep, input logic [7:0] q);
    proc_t p;
    p = '0;
    p.mode = m;
    case (m)
      MODE_PLAIN: begin
        if (b == sep) begin
          p.mode = MODE_START;
          p.valid = 1'b1;
          p.res.field_end = 1'b1;
        end else begin
          p.valid = 1'b1;
          p.res.has_byte = 1'b1;
          p.res.out_byte = b;
        end
      end
      MODE_QUOTED: begin
        if (b == q) begin
          p.mode = MODE_QSEEN;
        end else begin
          p.valid = 1'b1;
          p.res.has_byte = 1'b1;
          p.res.out_byte = b;
        end
      end
      MODE_QSEEN: begin
        if (b == q) begin
          p.mode = MODE_QUOTED;
          p.valid = 1'b1;
          p.res.has_byte = 1'b1;
          p.res.out_byte = b;
        end else if (b == sep) begin
          p.mode = MODE_START;
          p.valid = 1'b1;
          p.res.field_end = 1'b1;
        end else begin
          p.mode = MODE_AFTER;
        end
      end
      MODE_AFTER: begin
        if (b == sep) begin
          p.mode = MODE_START;
          p.valid = 1'b1;
          p.res.field_end = 1'b1;
        end
      end
      default: begin
        if (b == sep) begin
          p.mode = MODE_START;
          p.valid = 1'b1;
          p.res.field_end = 1'b1;
        end else if (b == q) begin
          p.mode = MODE_QUOTED;
        end else begin
          p.mode = MODE_PLAIN;
          p.valid = 1'b1;
          p.res.has_byte = 1'b1;
          p.res.out_byte = b;
        end
      end
    endcase
    return p;
  endfunction

  proc_t held_p;
  proc_t new_p;

  // held carriage return first, then the new byte
  always_comb begin
    held_p = proc_byte(BYTE_CR, mode_i, sep_i, quote_i);
    if (!pending_cr_i) begin
      held_p = '0;
      held_p.mode = mode_i;
    end
    new_p = proc_byte(in_byte_i, held_p.mode, sep_i, quote_i);
    if (in_byte_i == BYTE_CR) begin
      new_p = '0;
      new_p.mode = held_p.mode;
    end
  end

  // pack results in order and mark the final one
  always_comb begin
    step_o = '0;
    if (pending_cr_i && (in_byte_i == BYTE_LF)) begin
      step_o.num = 2'd1;
      step_o.res0.field_end = 1'b1;
      step_o.res0.row_end = 1'b1;
      step_o.res0.last = 1'b1;
      step_o.mode = MODE_START;
      step_o.pending_cr = 1'b0;
    end else begin
      step_o.mode = new_p.mode;
      step_o.pending_cr = (in_byte_i == BYTE_CR);
      if (held_p.valid && new_p.valid) begin
        step_o.num = 2'd2;
        step_o.res0 = held_p.res;
        step_o.res1 = new_p.res;
        step_o.res1.last = 1'b1;
      end else if (held_p.valid) begin
        step_o.num = 2'd1;
        step_o.res0 = held_p.res;
        step_o.res0.last = 1'b1;
      end else if (new_p.valid) begin
        step_o.num = 2'd1;
        step_o.res0 = new_p.res;
        step_o.res0.last = 1'b1;
      end
    end
  end

endmodule

>>> design/csvt_res_fifo.sv
module csvt_res_fifo import csvt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_num_i,
  input  result_t         push0_i,
  input  result_t         push1_i,
  input  logic            pop_i,
  output result_t         head_o,
  output logic            not_empty_o,
  output logic [CntW-1:0] count_o
);

  result_t           mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [PtrW-1:0]   wr_ptr_nxt;

  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_num_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    count_d  = count_q + CntW'(push_num_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // result storage, up to two writes a cycle
  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push1_i;
    end
  end

  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign count_o     = count_q;

endmodule

>>> design/csv_field_tokenizer_unit.sv
// channel  direction  handshake                      payload
// input    in         in_valid_i / in_ready_o        in_byte_i
// output   out        out_valid_o / out_ready_i      has_byte_o out_byte_o field_end_o
//                                                    row_end_o last_o
// config   in         psel penable pwrite / pready   paddr pwdata prdata
//
// one byte per cycle sustained while the output keeps up: a byte waits in the input
// register, is parsed in a single pass and its zero to two results enter a four-entry
// result fifo; results leave one per cycle, so the output port sets the rate
// a held byte leaves the input register only while the fifo has room for two results
// output stalls back up into the input channel once fewer than two fifo entries are free
// reset returns both registers to comma and double quote and the parser to field start
module csv_field_tokenizer_unit import csvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        has_byte_o,
  output logic [7:0]  out_byte_o,
  output logic        field_end_o,
  output logic        row_end_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]      sep_q, quote_q;
  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  field_mode_e     mode_q;
  logic            pending_cr_q;
  step_t           step;
  logic            proc_fire;
  logic [1:0]      push_num;
  logic            pop;
  result_t         head;
  logic            not_empty;
  logic [CntW-1:0] fifo_count;
  logic            cfg_wr;
  logic            reg_idx;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= SEP_RESET;
      quote_q <= QUOTE_RESET;
    end else if (cfg_wr) begin
      if (reg_idx == REG_SEPARATOR) begin
        sep_q <= pwdata[7:0];
      end else begin
        quote_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SEPARATOR) begin
      prdata[7:0] = sep_q;
    end else begin
      prdata[7:0] = quote_q;
    end
  end

  // byte is parsed once the fifo has room for two results
  assign proc_fire  = in_vld_q && (fifo_count <= CntW'(FifoDepth - 2));
  assign in_ready_o = !in_vld_q || proc_fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  // single pass parse
  csvt_step u_step (
    .in_byte_i    (in_byte_q),
    .mode_i       (mode_q),
    .pending_cr_i (pending_cr_q),
    .sep_i        (sep_q),
    .quote_i      (quote_q),
    .step_o       (step)
  );

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_START;
      pending_cr_q <= 1'b0;
    end else if (proc_fire) begin
      mode_q       <= step.mode;
      pending_cr_q <= step.pending_cr;
    end
  end

  // result fifo
  assign push_num = proc_fire ? step.num : 2'd0;
  assign pop      = not_empty && out_ready_i;

  csvt_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .push0_i     (step.res0),
    .push1_i     (step.res1),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .count_o     (fifo_count)
  );

  assign out_valid_o = not_empty;
  assign has_byte_o  = head.has_byte;
  assign out_byte_o  = head.out_byte;
  assign field_end_o = head.field_end;
  assign row_end_o   = head.row_end;
  assign last_o      = head.last;

  // fifo never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= CntW'(FifoDepth))
    else $error("result fifo overflow");

  // a row end always closes a field and ends its byte's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_end_o |-> field_end_o && last_o)
    else $error("row end without field end");

  // mark-only results carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> out_byte_o == 8'd0)
    else $error("stray byte on mark");

  // a stalled input byte stays in the register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !proc_fire |=> in_vld_q && $stable(in_byte_q))
    else $error("input byte lost");

endmodule
